>>> sv/hrt_pkg.sv
// ----------------------------------------------------------------------------
// hrt_pkg: shared types and constants for the handle registry table
// Holds the command and status codes, the field widths of the channels and
// the search flags that pass along the chain of cells and the broadcast write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hrt_pkg;

	localparam int HANDLE_W    = 16;
	localparam int STATUS_W    = 3;
	localparam int SLOT_OUT_W  = 8;
	localparam int COUNT_OUT_W = 9;

	typedef enum logic {
		CMD_REGISTER = 1'b0,
		CMD_RELEASE  = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_HELD      = 3'd0,
		ST_REUSED    = 3'd1,
		ST_APPENDED  = 3'd2,
		ST_FULL      = 3'd3,
		ST_RELEASED  = 3'd4,
		ST_NOT_FOUND = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_COMMIT
	} state_t;

	// Search token flags that ride down the chain with the key
	typedef struct packed {
		logic vld;
		logic hit;
		logic free;
	} scan_flags_t;

	// Broadcast write from the commit logic into the cells
	typedef struct packed {
		logic en;
		logic set;
	} cell_write_t;

endpackage

>>> sv/hrt_if.sv
// ----------------------------------------------------------------------------
// hrt_if: request and response channels of the handle registry table
// Valid/ready channels; a transaction completes when valid and ready are
// both high at a rising clock edge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hrt_req_if;
	logic                         valid;
	logic                         ready;
	logic                         command;
	logic [hrt_pkg::HANDLE_W-1:0] handle;

	modport source (output valid, output command, output handle, input ready);
	modport sink   (input valid, input command, input handle, output ready);
endinterface

interface hrt_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [hrt_pkg::STATUS_W-1:0]    status;
	logic [hrt_pkg::SLOT_OUT_W-1:0]  slot;
	logic [hrt_pkg::COUNT_OUT_W-1:0] live_count;
	logic [hrt_pkg::COUNT_OUT_W-1:0] high_water;
	logic [hrt_pkg::HANDLE_W-1:0]    largest_handle;
	logic                            largest_known;

	modport source (output valid, output status, output slot, output live_count,
		output high_water, output largest_handle, output largest_known, input ready);
	modport sink   (input valid, input status, input slot, input live_count,
		input high_water, input largest_handle, input largest_known, output ready);
endinterface

>>> sv/hrt_cell.sv
// ----------------------------------------------------------------------------
// hrt_cell: one slot of the handle registry table
// Stores one handle and its valid mark, checks the passing search token
// against them and hands the token on to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hrt_cell #(
	parameter int SLOT_W = 8,
	parameter int KEY_W  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [SLOT_W-1:0]    index,
	input  logic [SLOT_W:0]      mark,
	input  hrt_pkg::scan_flags_t flags_in,
	input  logic [KEY_W-1:0]     key_in,
	input  logic [SLOT_W-1:0]    hit_slot_in,
	input  logic [SLOT_W-1:0]    free_slot_in,
	output hrt_pkg::scan_flags_t flags_out,
	output logic [KEY_W-1:0]     key_out,
	output logic [SLOT_W-1:0]    hit_slot_out,
	output logic [SLOT_W-1:0]    free_slot_out,
	input  hrt_pkg::cell_write_t wr,
	input  logic [SLOT_W-1:0]    wr_slot,
	input  logic [KEY_W-1:0]     wr_key
);

	logic                 valid_q;
	logic [KEY_W-1:0]     store_q;
	hrt_pkg::scan_flags_t flags_q;
	logic [KEY_W-1:0]     key_q;
	logic [SLOT_W-1:0]    hit_slot_q;
	logic [SLOT_W-1:0]    free_slot_q;
	logic                 match;
	logic                 free_here;
	logic                 wr_here;

	assign match     = valid_q && (store_q == key_in);
	assign free_here = !valid_q && ({1'b0, index} < mark);
	assign wr_here   = wr.en && (wr_slot == index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			flags_q <= '0;
		end else begin
			if (wr_here) begin
				valid_q <= wr.set;
			end
			flags_q.vld  <= flags_in.vld;
			flags_q.hit  <= flags_in.hit | match;
			flags_q.free <= flags_in.free | free_here;
		end
	end

	// Keep the lowest matching and lowest free slot: earlier cells win
	always_ff @(posedge clk) begin
		if (wr_here && wr.set) begin
			store_q <= wr_key;
		end
		key_q       <= key_in;
		hit_slot_q  <= flags_in.hit ? hit_slot_in : index;
		free_slot_q <= flags_in.free ? free_slot_in : index;
	end

	assign flags_out     = flags_q;
	assign key_out       = key_q;
	assign hit_slot_out  = hit_slot_q;
	assign free_slot_out = free_slot_q;

endmodule

>>> sv/handle_registry_table.sv
// ----------------------------------------------------------------------------
// handle_registry_table: fixed table of registered handle numbers
// A request is taken only while idle; the search token walks the chain of
//   TABLE_SLOTS cells one cell per cycle, its result is captured at the tail
//   and committed once the response register is free or being drained.
// A finished response waits in its output register while the next request
//   is taken. Reset clears all valid marks and counters at once, no sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module handle_registry_table #(
	parameter int TABLE_SLOTS = 256,
	parameter int HANDLE_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	hrt_req_if.sink  req,
	hrt_rsp_if.source rsp
);

	localparam int SLOT_W = $clog2(TABLE_SLOTS);
	localparam int MARK_W = SLOT_W + 1;
	// Only the low bits of the 16-bit handle field can ever be significant
	localparam int KEY_W  = (HANDLE_BITS < hrt_pkg::HANDLE_W) ? HANDLE_BITS
		: hrt_pkg::HANDLE_W;

	// Request and search results
	hrt_pkg::state_t  state_q, state_d;
	hrt_pkg::cmd_t    cmd_q;
	logic [KEY_W-1:0] key_q;
	logic             hit_q, free_q;
	logic [SLOT_W-1:0] hit_slot_q, free_slot_q;

	// Table bookkeeping
	logic [MARK_W-1:0] used_q, held_q;
	logic [KEY_W-1:0]  max_q;
	logic              seen_q;

	// Response holding register
	logic                            rsp_vld_q;
	hrt_pkg::status_t                out_status_q;
	logic [hrt_pkg::SLOT_OUT_W-1:0]  out_slot_q;
	logic [hrt_pkg::COUNT_OUT_W-1:0] out_live_q, out_high_q;
	logic [hrt_pkg::HANDLE_W-1:0]    out_largest_q;
	logic                            out_known_q;

	// Control strobes
	logic inject, scan_done, load;

	// Commit results
	hrt_pkg::status_t     status_c;
	logic [SLOT_W-1:0]    slot_c;
	logic [MARK_W-1:0]    used_n, held_n;
	logic [KEY_W-1:0]     max_n;
	logic                 seen_n;
	hrt_pkg::cell_write_t wr_c, wr_bus;

	// Chain links; link 0 feeds the first cell, link TABLE_SLOTS is the tail
	hrt_pkg::scan_flags_t chain_flags [TABLE_SLOTS+1];
	logic [KEY_W-1:0]     chain_key   [TABLE_SLOTS+1];
	logic [SLOT_W-1:0]    chain_hit   [TABLE_SLOTS+1];
	logic [SLOT_W-1:0]    chain_free  [TABLE_SLOTS+1];

	// ------------------------------------------------------------------
	// Sequencer: idle, let the token walk the chain, then commit
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hrt_pkg::S_IDLE: begin
				if (req.valid) begin
					state_d = hrt_pkg::S_SCAN;
				end
			end
			hrt_pkg::S_SCAN: begin
				if (chain_flags[TABLE_SLOTS].vld) begin
					state_d = hrt_pkg::S_COMMIT;
				end
			end
			hrt_pkg::S_COMMIT: begin
				if (!rsp_vld_q || rsp.ready) begin
					state_d = hrt_pkg::S_IDLE;
				end
			end
			default: state_d = hrt_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		req.ready = (state_q == hrt_pkg::S_IDLE);
		inject    = req.ready && req.valid;
		scan_done = (state_q == hrt_pkg::S_SCAN) && chain_flags[TABLE_SLOTS].vld;
		// Commit only once the response register is free or being drained
		load      = (state_q == hrt_pkg::S_COMMIT) && (!rsp_vld_q || rsp.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hrt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ------------------------------------------------------------------
	// Capture the request and, at the tail, the search result
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (inject) begin
			cmd_q <= hrt_pkg::cmd_t'(req.command);
			key_q <= KEY_W'(req.handle);
		end
		if (scan_done) begin
			hit_q       <= chain_flags[TABLE_SLOTS].hit;
			free_q      <= chain_flags[TABLE_SLOTS].free;
			hit_slot_q  <= chain_hit[TABLE_SLOTS];
			free_slot_q <= chain_free[TABLE_SLOTS];
		end
	end

	// ------------------------------------------------------------------
	// Commit decision: held, reuse the lowest free slot, append or full;
	// release reports not found or clears the lowest matching slot
	// ------------------------------------------------------------------
	always_comb begin
		status_c = hrt_pkg::ST_NOT_FOUND;
		slot_c   = '0;
		used_n   = used_q;
		held_n   = held_q;
		max_n    = max_q;
		seen_n   = seen_q;
		wr_c     = '0;
		if (cmd_q == hrt_pkg::CMD_REGISTER) begin
			// Track the largest handle even when the table is full
			if (!seen_q || (key_q > max_q)) begin
				max_n = key_q;
			end
			seen_n = 1'b1;
			if (hit_q) begin
				status_c = hrt_pkg::ST_HELD;
				slot_c   = hit_slot_q;
			end else if (free_q) begin
				status_c = hrt_pkg::ST_REUSED;
				slot_c   = free_slot_q;
				wr_c.en  = 1'b1;
				wr_c.set = 1'b1;
				held_n   = held_q + 1'b1;
			end else if (used_q < MARK_W'(TABLE_SLOTS)) begin
				status_c = hrt_pkg::ST_APPENDED;
				slot_c   = used_q[SLOT_W-1:0];
				wr_c.en  = 1'b1;
				wr_c.set = 1'b1;
				used_n   = used_q + 1'b1;
				held_n   = held_q + 1'b1;
			end else begin
				status_c = hrt_pkg::ST_FULL;
			end
		end else if (hit_q) begin
			status_c = hrt_pkg::ST_RELEASED;
			slot_c   = hit_slot_q;
			wr_c.en  = 1'b1;
			wr_c.set = 1'b0;
			if (held_q != '0) begin
				held_n = held_q - 1'b1;
			end
		end
	end

	assign wr_bus.en  = wr_c.en && load;
	assign wr_bus.set = wr_c.set;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			held_q    <= '0;
			max_q     <= '0;
			seen_q    <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (load) begin
				used_q    <= used_n;
				held_q    <= held_n;
				max_q     <= max_n;
				seen_q    <= seen_n;
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	// Hold the response payload until the transaction completes
	always_ff @(posedge clk) begin
		if (load) begin
			out_status_q  <= status_c;
			out_slot_q    <= hrt_pkg::SLOT_OUT_W'(slot_c);
			out_live_q    <= hrt_pkg::COUNT_OUT_W'(held_n);
			out_high_q    <= hrt_pkg::COUNT_OUT_W'(used_n);
			out_largest_q <= hrt_pkg::HANDLE_W'(max_n);
			out_known_q   <= seen_n;
		end
	end

	assign rsp.valid          = rsp_vld_q;
	assign rsp.status         = out_status_q;
	assign rsp.slot           = out_slot_q;
	assign rsp.live_count     = out_live_q;
	assign rsp.high_water     = out_high_q;
	assign rsp.largest_handle = out_largest_q;
	assign rsp.largest_known  = out_known_q;

	// ------------------------------------------------------------------
	// Chain of slot cells; a fresh token enters at the head on a request
	// ------------------------------------------------------------------
	assign chain_flags[0].vld  = inject;
	assign chain_flags[0].hit  = 1'b0;
	assign chain_flags[0].free = 1'b0;
	assign chain_key[0]        = KEY_W'(req.handle);
	assign chain_hit[0]        = '0;
	assign chain_free[0]       = '0;

	for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
		hrt_cell #(
			.SLOT_W (SLOT_W),
			.KEY_W  (KEY_W)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.index         (SLOT_W'(g)),
			.mark          (used_q),
			.flags_in      (chain_flags[g]),
			.key_in        (chain_key[g]),
			.hit_slot_in   (chain_hit[g]),
			.free_slot_in  (chain_free[g]),
			.flags_out     (chain_flags[g+1]),
			.key_out       (chain_key[g+1]),
			.hit_slot_out  (chain_hit[g+1]),
			.free_slot_out (chain_free[g+1]),
			.wr            (wr_bus),
			.wr_slot       (slot_c),
			.wr_key        (key_q)
		);
	end

`ifndef SYNTHESIS
	a_live_le_mark: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= used_q)
		else $error("live count exceeds high-water mark");

	a_mark_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= MARK_W'(TABLE_SLOTS))
		else $error("high-water mark beyond table size");

	a_tail_only_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		chain_flags[TABLE_SLOTS].vld |-> (state_q == hrt_pkg::S_SCAN))
		else $error("search token left the chain outside a scan");

	a_append_bumps_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(load && (status_c == hrt_pkg::ST_APPENDED)) |=>
		(used_q == $past(used_q) + 1'b1))
		else $error("append did not advance the high-water mark");
`endif

endmodule
